/* rtl/best_fit_block_allocator_macros.svh */
// -----------------------------------------------------------------------------
// best_fit_block_allocator_macros.svh
// Assertion shorthands for the best-fit allocator. Expect clk and arst_n in scope.
// -----------------------------------------------------------------------------
`ifndef BEST_FIT_BLOCK_ALLOCATOR_MACROS_SVH
`define BEST_FIT_BLOCK_ALLOCATOR_MACROS_SVH

// same-cycle implication
`define BFBA_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bfba assertion failed");

// next-cycle implication
`define BFBA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bfba assertion failed");

`endif

/* rtl/bfba_pkg.sv */
// -----------------------------------------------------------------------------
// bfba_pkg
// Types and constants shared by the best-fit allocator modules.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bfba_pkg;

	localparam int MAX_BLOCKS_DEF = 64;
	localparam int CFG_W          = 7;
	localparam int SIZE_W         = 16;
	localparam int PID_W          = 16;
	localparam int BIDX_W         = 6;

	localparam logic [PID_W-1:0] NO_OWNER = 16'hFFFF;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_ALLOC = 1'b1;

	localparam logic [1:0] STAT_LOADED = 2'd0;
	localparam logic [1:0] STAT_ALLOC  = 2'd1;
	localparam logic [1:0] STAT_WAIT   = 2'd2;

	typedef struct packed {
		logic              operation;
		logic [BIDX_W-1:0] block_index;
		logic [SIZE_W-1:0] size;
		logic              block_free;
		logic [PID_W-1:0]  process_id;
	} cmd_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [BIDX_W-1:0] chosen_block;
	} res_t;

	// table port controls
	typedef struct packed {
		logic wr_en;
		logic size_wr;
		logic free_val;
		logic rd_en;
	} tbl_ctl_t;

endpackage

/* rtl/bfba_table.sv */
// -----------------------------------------------------------------------------
// bfba_table
// Block table: size and owner memories, free flags in resettable flops.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bfba_table #(
	parameter int MAX_BLOCKS = bfba_pkg::MAX_BLOCKS_DEF,
	parameter int IDX_W      = $clog2(MAX_BLOCKS)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  bfba_pkg::tbl_ctl_t           ctl,
	input  logic [IDX_W-1:0]             wr_addr,
	input  logic [bfba_pkg::SIZE_W-1:0]  wr_size,
	input  logic [bfba_pkg::PID_W-1:0]   wr_owner,
	input  logic [IDX_W-1:0]             rd_addr,
	output logic [bfba_pkg::SIZE_W-1:0]  rd_size,
	output logic                         rd_free
);

	logic [bfba_pkg::SIZE_W-1:0] size_mem [MAX_BLOCKS];
	logic [bfba_pkg::PID_W-1:0]  owner_mem [MAX_BLOCKS];
	logic [MAX_BLOCKS-1:0]       free_q;
	logic [bfba_pkg::SIZE_W-1:0] rd_size_q;
	logic                        rd_free_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en && ctl.size_wr) begin
			size_mem[wr_addr] <= wr_size;
		end
		if (ctl.wr_en) begin
			owner_mem[wr_addr] <= wr_owner;
		end
		if (ctl.rd_en) begin
			rd_size_q <= size_mem[rd_addr];
			rd_free_q <= free_q[rd_addr];
		end
	end

	// never-loaded entries stay not free, so stale sizes are never used
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_q <= '0;
		end else if (ctl.wr_en) begin
			free_q[wr_addr] <= ctl.free_val;
		end
	end

	assign rd_size = rd_size_q;
	assign rd_free = rd_free_q;

endmodule

/* rtl/bfba_seq.sv */
// -----------------------------------------------------------------------------
// bfba_seq
// Sequencer and shared compare unit: one table entry examined per cycle.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "best_fit_block_allocator_macros.svh"

module bfba_seq #(
	parameter int MAX_BLOCKS = bfba_pkg::MAX_BLOCKS_DEF,
	parameter int IDX_W      = $clog2(MAX_BLOCKS)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  bfba_pkg::cmd_t               cmd,
	input  logic [bfba_pkg::CFG_W-1:0]   blocks_in_use,
	output logic                         busy,
	output logic                         done,
	output bfba_pkg::res_t               result,
	output bfba_pkg::tbl_ctl_t           ctl,
	output logic [IDX_W-1:0]             wr_addr,
	output logic [bfba_pkg::SIZE_W-1:0]  wr_size,
	output logic [bfba_pkg::PID_W-1:0]   wr_owner,
	output logic [IDX_W-1:0]             rd_addr,
	input  logic [bfba_pkg::SIZE_W-1:0]  rd_size,
	input  logic                         rd_free
);

	localparam int LIM_W = $clog2(MAX_BLOCKS + 1);
	localparam int CNT_W = (LIM_W > bfba_pkg::CFG_W) ? LIM_W : bfba_pkg::CFG_W;

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_SCAN   = 4'b0010,
		S_FLUSH  = 4'b0100,
		S_COMMIT = 4'b1000
	} state_t;

	state_t                      state_q;
	logic                        op_q;
	logic [bfba_pkg::SIZE_W-1:0] req_q;
	logic [bfba_pkg::PID_W-1:0]  pid_q;
	logic [IDX_W-1:0]            addr_q;
	logic [IDX_W-1:0]            last_q;
	logic                        vld_s1;
	logic [IDX_W-1:0]            idx_s1;
	logic                        found_q;
	logic [bfba_pkg::SIZE_W-1:0] best_size_q;
	logic [IDX_W-1:0]            best_q;
	logic                        done_q;
	bfba_pkg::res_t              res_q;

	logic                        accept;
	logic [CNT_W-1:0]            lim_raw;
	logic [CNT_W-1:0]            lim;
	logic                        idx_ok;
	logic                        hit;

	assign accept  = start && (state_q == S_IDLE);
	assign lim_raw = CNT_W'(blocks_in_use);
	assign lim     = (lim_raw > CNT_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : lim_raw;
	assign idx_ok  = CNT_W'(cmd.block_index) < CNT_W'(MAX_BLOCKS);

	// shared compare unit: free, large enough, strictly smaller than best so far
	assign hit = vld_s1 && rd_free && (rd_size >= req_q) &&
		(!found_q || (rd_size < best_size_q));

	// table port: load write at accept, allocation commit at the end
	always_comb begin
		ctl      = '0;
		wr_addr  = best_q;
		wr_size  = cmd.size;
		wr_owner = pid_q;
		rd_addr  = addr_q;
		if (accept && (cmd.operation == bfba_pkg::OP_LOAD) && idx_ok) begin
			ctl.wr_en    = 1'b1;
			ctl.size_wr  = 1'b1;
			ctl.free_val = cmd.block_free;
			wr_addr      = IDX_W'(cmd.block_index);
			wr_owner     = cmd.block_free ? bfba_pkg::NO_OWNER : cmd.process_id;
		end else if ((state_q == S_COMMIT) && (op_q == bfba_pkg::OP_ALLOC) && found_q) begin
			ctl.wr_en    = 1'b1;
			ctl.free_val = 1'b0;
		end
		ctl.rd_en = (state_q == S_SCAN);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			vld_s1  <= 1'b0;
			found_q <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			vld_s1 <= 1'b0;
			if (hit) begin
				found_q <= 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						found_q <= 1'b0;
						if ((cmd.operation == bfba_pkg::OP_ALLOC) && (lim != '0)) begin
							state_q <= S_SCAN;
						end else begin
							state_q <= S_COMMIT;
						end
					end
				end
				S_SCAN: begin
					vld_s1 <= 1'b1;
					if (addr_q == last_q) begin
						state_q <= S_FLUSH;
					end
				end
				S_FLUSH: begin
					state_q <= S_COMMIT;
				end
				S_COMMIT: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= cmd.operation;
			req_q  <= cmd.size;
			pid_q  <= cmd.process_id;
			addr_q <= '0;
			last_q <= IDX_W'(lim - CNT_W'(1));
		end else if ((state_q == S_SCAN) && (addr_q != last_q)) begin
			addr_q <= addr_q + IDX_W'(1);
		end
		if (state_q == S_SCAN) begin
			idx_s1 <= addr_q;
		end
		if (hit) begin
			best_size_q <= rd_size;
			best_q      <= idx_s1;
		end
		if (state_q == S_COMMIT) begin
			if (op_q == bfba_pkg::OP_LOAD) begin
				res_q.status       <= bfba_pkg::STAT_LOADED;
				res_q.chosen_block <= '0;
			end else if (found_q) begin
				res_q.status       <= bfba_pkg::STAT_ALLOC;
				res_q.chosen_block <= bfba_pkg::BIDX_W'(best_q);
			end else begin
				res_q.status       <= bfba_pkg::STAT_WAIT;
				res_q.chosen_block <= '0;
			end
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = res_q;

	`BFBA_ASSERT_NOW(a_done_idle, done_q, state_q == S_IDLE)
	`BFBA_ASSERT_NOW(a_vld_scan, vld_s1, (state_q == S_SCAN) || (state_q == S_FLUSH))
	`BFBA_ASSERT_NOW(a_best_in_range, (state_q == S_COMMIT) && found_q, best_q <= last_q)
	`BFBA_ASSERT_NEXT(a_scan_start,
		accept && (cmd.operation == bfba_pkg::OP_ALLOC) && (lim != '0), state_q == S_SCAN)

endmodule

/* rtl/best_fit_block_allocator.sv */
// -----------------------------------------------------------------------------
// best_fit_block_allocator
// Best-fit allocator over a table of fixed memory blocks.
// -----------------------------------------------------------------------------
// Usage:
//  - Command channel: an item (cmd) is taken on a clock edge with start high
//    and busy low. A load item writes one table entry; an allocate item scans
//    entries 0 .. blocks_in_use-1 (clamped to MAX_BLOCKS) for the smallest free
//    block that fits, lowest index on a tie, and marks it taken.
//  - Result: done pulses for one cycle with result valid; there is no stall,
//    the receiver must take it in that cycle.
//  - Sequence: a load goes from accept straight to the commit state, as does an
//    allocation when N, the clamped blocks_in_use, is zero. Otherwise an
//    allocation passes through the scan, a flush state and the commit state.
//    The scan reads one entry of the size memory per cycle through its single
//    read port.
//  - One item at a time; busy stays high until the result goes out, and a
//    new item may be accepted in the cycle done is high.
//  - Config: cfg_data writes blocks_in_use when cfg_valid is high; cfg_ready
//    is always high. Write it only while the block is idle.
//  - Reset: all free flags clear (no block free), blocks_in_use = 0, sequencer
//    idle. Sizes and owners are undefined until an entry is loaded.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module best_fit_block_allocator #(
	parameter int MAX_BLOCKS = bfba_pkg::MAX_BLOCKS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// command channel
	input  logic                        start,
	output logic                        busy,
	input  bfba_pkg::cmd_t              cmd,
	// result strobe
	output logic                        done,
	output bfba_pkg::res_t              result,
	// config write
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [bfba_pkg::CFG_W-1:0]  cfg_data
);

	localparam int IDX_W = $clog2(MAX_BLOCKS);

	logic [bfba_pkg::CFG_W-1:0]  blocks_in_use_q;
	bfba_pkg::tbl_ctl_t          ctl;
	logic [IDX_W-1:0]            wr_addr;
	logic [bfba_pkg::SIZE_W-1:0] wr_size;
	logic [bfba_pkg::PID_W-1:0]  wr_owner;
	logic [IDX_W-1:0]            rd_addr;
	logic [bfba_pkg::SIZE_W-1:0] rd_size;
	logic                        rd_free;

	// config register; no back-pressure needed
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blocks_in_use_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			blocks_in_use_q <= cfg_data;
		end
	end

	// sequencer with the shared compare unit
	bfba_seq #(
		.MAX_BLOCKS (MAX_BLOCKS),
		.IDX_W      (IDX_W)
	) u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.cmd           (cmd),
		.blocks_in_use (blocks_in_use_q),
		.busy          (busy),
		.done          (done),
		.result        (result),
		.ctl           (ctl),
		.wr_addr       (wr_addr),
		.wr_size       (wr_size),
		.wr_owner      (wr_owner),
		.rd_addr       (rd_addr),
		.rd_size       (rd_size),
		.rd_free       (rd_free)
	);

	// block table: registered read, one write port
	bfba_table #(
		.MAX_BLOCKS (MAX_BLOCKS),
		.IDX_W      (IDX_W)
	) u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.wr_addr  (wr_addr),
		.wr_size  (wr_size),
		.wr_owner (wr_owner),
		.rd_addr  (rd_addr),
		.rd_size  (rd_size),
		.rd_free  (rd_free)
	);

endmodule

/* verif/testbench.sv */
// -----------------------------------------------------------------------------
// testbench
// Self-checking bench for the best-fit block allocator: loads table entries,
// issues allocation requests under several block counts and compares every
// result strobe against an in-bench best-fit predictor.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

	localparam int TABLE_DEPTH    = bfba_pkg::MAX_BLOCKS_DEF;
	localparam int PHASE_ITEMS    = 68;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int END_SETTLE     = 80;

	logic                          clk       = 1'b0;
	logic                          arst_n    = 1'b0;
	logic                          start     = 1'b0;
	logic                          busy;
	bfba_pkg::cmd_t                cmd       = '0;
	logic                          done;
	bfba_pkg::res_t                result;
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic [bfba_pkg::CFG_W-1:0]    cfg_data  = '0;

	// stimulus side
	bfba_pkg::cmd_t                pending_cmds[$];
	bit                            entry_loaded[TABLE_DEPTH];
	logic                          hold_sender   = 1'b0;
	logic                          steady_sender = 1'b0;
	int                            burst_left    = 0;
	int                            gap_left      = 0;

	// predictor state: shadow of the block table and its search count
	logic [bfba_pkg::SIZE_W-1:0]   shadow_size[TABLE_DEPTH];
	logic                          shadow_free[TABLE_DEPTH];
	logic [bfba_pkg::PID_W-1:0]    shadow_owner[TABLE_DEPTH];
	logic [bfba_pkg::CFG_W-1:0]    shadow_count = '0;
	bfba_pkg::res_t                expected_results[$];

	int                            fail_count = 0;
	int                            quiet_cycles = 0;
	int                            n_loads = 0;
	int                            n_grants = 0;
	int                            n_waits = 0;
	int                            n_cfg = 0;

	best_fit_block_allocator i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Best-fit prediction for one accepted item; updates the shadow table.
	function automatic bfba_pkg::res_t predict_best_fit(input bfba_pkg::cmd_t c);
		bfba_pkg::res_t              r;
		int                          lim;
		int                          best;
		logic [bfba_pkg::SIZE_W-1:0] best_size;
		r         = '0;
		best      = -1;
		best_size = '0;
		if (c.operation == bfba_pkg::OP_LOAD) begin
			shadow_size[c.block_index]  = c.size;
			shadow_free[c.block_index]  = c.block_free;
			// a free block carries no owner, whatever pid came with it
			shadow_owner[c.block_index] = c.block_free ? bfba_pkg::NO_OWNER : c.process_id;
			r.status = bfba_pkg::STAT_LOADED;
			return r;
		end
		// counts above the table depth search the whole table
		lim = (int'(shadow_count) > TABLE_DEPTH) ? TABLE_DEPTH : int'(shadow_count);
		for (int i = 0; i < lim; i++) begin
			if (shadow_free[i] && shadow_size[i] >= c.size &&
			    (best < 0 || shadow_size[i] < best_size)) begin
				best      = i;
				best_size = shadow_size[i];
			end
		end
		if (best >= 0) begin
			shadow_free[best]  = 1'b0;
			shadow_owner[best] = c.process_id;
			r.status           = bfba_pkg::STAT_ALLOC;
			r.chosen_block     = bfba_pkg::BIDX_W'(best);
		end else begin
			r.status = bfba_pkg::STAT_WAIT;
		end
		return r;
	endfunction

	// Block sizes cluster on multiples of 64 so ties and near misses are common.
	function automatic logic [bfba_pkg::SIZE_W-1:0] pick_block_size();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			2, 3, 4, 5: return bfba_pkg::SIZE_W'(64 * $urandom_range(1, 8));
			default: return bfba_pkg::SIZE_W'($urandom_range(0, 65535));
		endcase
	endfunction

	function automatic logic [bfba_pkg::SIZE_W-1:0] pick_request_size();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			2, 3, 4, 5, 6:
				return bfba_pkg::SIZE_W'(64 * $urandom_range(1, 8) - $urandom_range(0, 1));
			default: return bfba_pkg::SIZE_W'($urandom_range(0, 65535));
		endcase
	endfunction

	task automatic queue_load(input int idx, input logic [bfba_pkg::SIZE_W-1:0] sz,
	                          input logic is_free, input logic [bfba_pkg::PID_W-1:0] pid);
		bfba_pkg::cmd_t c;
		c.operation   = bfba_pkg::OP_LOAD;
		c.block_index = bfba_pkg::BIDX_W'(idx);
		c.size        = sz;
		c.block_free  = is_free;
		c.process_id  = pid;
		entry_loaded[idx] = 1'b1;
		pending_cmds.push_back(c);
	endtask

	task automatic queue_alloc(input logic [bfba_pkg::SIZE_W-1:0] sz,
	                           input logic [bfba_pkg::PID_W-1:0] pid);
		bfba_pkg::cmd_t c;
		c.operation   = bfba_pkg::OP_ALLOC;
		// index and free flag are don't-care on an allocation; toggle them anyway
		c.block_index = bfba_pkg::BIDX_W'($urandom_range(0, TABLE_DEPTH - 1));
		c.size        = sz;
		c.block_free  = 1'($urandom_range(0, 1));
		c.process_id  = pid;
		pending_cmds.push_back(c);
	endtask

	// Mostly loads into the searched range and allocations sized to hit them.
	task automatic queue_random_item(input int lim);
		int idx;
		if ($urandom_range(0, 1) == 0) begin
			idx = (lim > 0 && $urandom_range(0, 4) != 0) ? $urandom_range(0, lim - 1)
			                                             : $urandom_range(0, TABLE_DEPTH - 1);
			queue_load(idx, pick_block_size(), $urandom_range(0, 6) != 0,
			           bfba_pkg::PID_W'($urandom_range(0, 65535)));
		end else begin
			queue_alloc(pick_request_size(), bfba_pkg::PID_W'($urandom_range(0, 65535)));
		end
	endtask

	task automatic wait_idle();
		@(posedge clk);
		while (pending_cmds.size() != 0 || start || expected_results.size() != 0)
			@(posedge clk);
	endtask

	// Every entry the new count exposes gets loaded first, so the scan never
	// touches an unwritten size or owner.
	task automatic set_block_count(input int unsigned count);
		int i;
		for (i = 0; i < TABLE_DEPTH && i < int'(count); i++) begin
			if (!entry_loaded[i])
				queue_load(i, pick_block_size(), 1'($urandom_range(0, 1)),
				           bfba_pkg::PID_W'($urandom_range(0, 65535)));
		end
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data  <= bfba_pkg::CFG_W'(count);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// Sender: bursts of items with random gaps timed from the last accept, so
	// start rises at every point of a scan.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start      <= 1'b0;
			cmd        <= '0;
			burst_left <= 0;
			gap_left   <= 0;
		end else if (!start || !busy) begin
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				start    <= 1'b0;
			end else if (!hold_sender && pending_cmds.size() != 0) begin
				start <= 1'b1;
				cmd   <= pending_cmds.pop_front();
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 12);
					gap_left   <= (steady_sender || $urandom_range(0, 2) == 0) ? 0
					                                                       : $urandom_range(1, 80);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: checks each strobe, then predicts the item accepted at this edge.
	// A new item may go in on the edge that ends a done cycle, so the check
	// comes first.
	always @(posedge clk) begin
		bfba_pkg::res_t want;
		if (arst_n) begin
			if (done) begin
				if (expected_results.size() == 0) begin
					$error("unexpected result: status %0d chosen_block %0d",
					       result.status, result.chosen_block);
					fail_count++;
				end else begin
					want = expected_results.pop_front();
					if (result.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, result.status);
						fail_count++;
					end
					if (result.chosen_block !== want.chosen_block) begin
						$error("chosen_block: expected %0d, got %0d",
						       want.chosen_block, result.chosen_block);
						fail_count++;
					end
					case (want.status)
						bfba_pkg::STAT_LOADED: n_loads++;
						bfba_pkg::STAT_ALLOC:  n_grants++;
						default:               n_waits++;
					endcase
				end
			end
			if (cfg_valid && cfg_ready) begin
				shadow_count = cfg_data;
				n_cfg++;
			end
			if (start && !busy)
				expected_results.push_back(predict_best_fit(cmd));
			// watchdog on handshake activity
			if ((start && !busy) || done || (cfg_valid && cfg_ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= WATCHDOG_LIMIT) begin
					$display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
					$display("FAIL");
					$finish;
				end
			end
		end
	end

	initial begin
		int          ph;
		int unsigned count;
		int          lim;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty search range, then a hand-built table
		queue_alloc(16'd0, 16'h1234);                 // count zero: must wait
		queue_load(0, 16'd0, 1'b1, 16'h0000);
		queue_load(1, 16'hFFFF, 1'b1, 16'h5555);
		queue_load(2, 16'd100, 1'b0, 16'hABCD);       // occupied, same size as 3/4
		queue_load(3, 16'd100, 1'b1, 16'h0001);
		queue_load(4, 16'd100, 1'b1, 16'hFFFF);
		queue_load(5, 16'd50, 1'b1, 16'h7777);
		queue_load(63, 16'd7, 1'b1, 16'h8000);        // top index
		set_block_count(6);
		queue_alloc(16'd100, 16'h0100);               // tie 3/4: lowest wins
		queue_alloc(16'd100, 16'h0200);
		queue_alloc(16'd100, 16'h0300);               // falls to the max-size block
		queue_alloc(16'hFFFF, 16'hFFFF);              // nothing left that big
		queue_alloc(16'd0, 16'h0000);                 // zero request takes size 0
		queue_alloc(16'd0, 16'h0400);
		queue_alloc(16'd1, 16'h0500);
		queue_load(1, 16'hFFFF, 1'b1, 16'h0000);
		queue_alloc(16'hFFFF, 16'hFFFF);              // exact fit at max size
		set_block_count(127);                         // above depth: whole table
		queue_alloc(16'd7, 16'h0600);
		queue_alloc(16'd1, 16'h0700);

		// random phases over a spread of block counts
		for (ph = 0; ph < 10; ph++) begin
			case (ph)
				0:       count = 64;
				1:       count = 127;
				2:       count = 1;
				3:       count = 0;
				4:       count = $urandom_range(2, 63);
				5:       count = 65;
				6:       count = 2;
				8:       count = $urandom_range(1, 64);
				default: count = 64;
			endcase
			set_block_count(count);
			lim = (int'(count) > TABLE_DEPTH) ? TABLE_DEPTH : int'(count);
			steady_sender <= (ph % 3 == 1);
			repeat (PHASE_ITEMS) queue_random_item(lim);
			if (ph == 7) begin
				// hold the sender mid-phase until the block has drained
				while (pending_cmds.size() > PHASE_ITEMS / 2) @(posedge clk);
				hold_sender <= 1'b1;
				@(posedge clk);
				while (start || expected_results.size() != 0) @(posedge clk);
				hold_sender <= 1'b0;
			end
		end

		wait_idle();
		repeat (END_SETTLE) @(posedge clk);
		if (expected_results.size() != 0) begin
			$error("%0d results never arrived", expected_results.size());
			fail_count++;
		end
		$display("Covered %0d loads, %0d grants and %0d no-fit answers", n_loads, n_grants, n_waits);
		$display("across %0d block-count writes, extremes 0 and 127 included.", n_cfg);
		if (fail_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

/* filelist.f */
+incdir+rtl
rtl/bfba_pkg.sv
rtl/bfba_table.sv
rtl/bfba_seq.sv
rtl/best_fit_block_allocator.sv
verif/testbench.sv
